@@ rtl/radix_text_to_integer_parser_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the radix text-to-integer parser
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RADIX_TEXT_TO_INTEGER_PARSER_ASSERT_SVH
`define RADIX_TEXT_TO_INTEGER_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTTIP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rttip assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RTTIP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rttip assertion failed");

`endif

@@ rtl/rttip_pkg.sv @@
// ----------------------------------------------------------------------------
// rttip_pkg
// Shared widths, codes, reset constants and word types of the parser.
// ----------------------------------------------------------------------------
package rttip_pkg;

    localparam int CHAR_W      = 8;
    localparam int BASE_W      = 6;
    localparam int VALUE_W     = 64;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int DIV_STEPS   = VALUE_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [BASE_W-1:0]  DIGIT_NONE  = 6'd36;
    localparam logic [BASE_W-1:0]  BASE_MIN    = 6'd2;
    localparam logic [BASE_W-1:0]  BASE_MAX    = 6'd36;
    localparam logic [BASE_W-1:0]  BASE_RESET  = 6'd10;
    localparam logic [VALUE_W-1:0] LIMIT_RESET = '1;
    localparam logic [VALUE_W-1:0] QUOT_RESET  = 64'd1844674407370955161;
    localparam logic [BASE_W-1:0]  REM_RESET   = 6'd5;

    localparam logic [CFG_INDEX_W-1:0] CFG_BASE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        PROG_NONE   = 2'd0,
        PROG_DIGITS = 2'd1,
        PROG_OVER   = 2'd2
    } prog_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // One decoded character word held in the input stage.
    typedef struct packed {
        logic [BASE_W-1:0] digit;
        logic              present;
        logic              last;
    } char_word_t;

    // Radix and the precomputed cutoff split of the limit.
    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [VALUE_W-1:0] quotient;
        logic [BASE_W-1:0]  remainder;
    } limit_set_t;

endpackage

@@ rtl/rttip_in_stage.sv @@
// ----------------------------------------------------------------------------
// rttip_in_stage
// Input register: decodes one ASCII character to a digit value and holds it.
// ----------------------------------------------------------------------------
module rttip_in_stage (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [rttip_pkg::CHAR_W-1:0] character,
    input  logic                         char_present,
    input  logic                         last_char,
    input  logic                         hold,
    input  logic                         advance,
    output logic                         word_valid,
    output rttip_pkg::char_word_t        word
);
    import rttip_pkg::*;

    localparam logic [CHAR_W-1:0] ZERO_CH  = 8'h30;
    localparam logic [CHAR_W-1:0] NINE_CH  = 8'h39;
    localparam logic [CHAR_W-1:0] UPPER_A  = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] LOWER_A  = 8'h61;
    localparam logic [CHAR_W-1:0] LOWER_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] UPPER_OFS = UPPER_A - 8'd10;
    localparam logic [CHAR_W-1:0] LOWER_OFS = LOWER_A - 8'd10;

    logic        valid_reg, valid_next;
    char_word_t  word_reg;
    char_word_t  word_dec;
    logic        accept;

    always_comb
    begin
        word_dec.present = char_present;
        word_dec.last    = last_char;
        if (character >= ZERO_CH && character <= NINE_CH)
        begin
            word_dec.digit = BASE_W'(character - ZERO_CH);
        end
        else if (character >= UPPER_A && character <= UPPER_Z)
        begin
            word_dec.digit = BASE_W'(character - UPPER_OFS);
        end
        else if (character >= LOWER_A && character <= LOWER_Z)
        begin
            word_dec.digit = BASE_W'(character - LOWER_OFS);
        end
        else
        begin
            word_dec.digit = DIGIT_NONE;
        end
    end

    // Stall while the cutoff is recomputed or the held word cannot move on.
    assign in_stall = hold | (valid_reg & ~advance);
    assign accept   = in_valid & ~in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_dec;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

@@ rtl/rttip_limit_div.sv @@
// ----------------------------------------------------------------------------
// rttip_limit_div
// Configuration registers and a bit-serial divider for limit / base.
// ----------------------------------------------------------------------------
`include "radix_text_to_integer_parser_assert.svh"

module rttip_limit_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rttip_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rttip_pkg::VALUE_W-1:0]     cfg_data,
    output logic                              busy,
    output rttip_pkg::limit_set_t             limits
);
    import rttip_pkg::*;

    logic [BASE_W-1:0]  base_reg, base_next;
    logic [VALUE_W-1:0] limit_reg, limit_next;
    logic [VALUE_W-1:0] dvd_reg, dvd_next;
    logic [BASE_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [BASE_W-1:0]  base_wr;
    logic [BASE_W:0]    trial;
    logic               ge;
    logic               cfg_write;

    assign cfg_ready = ~busy_reg;
    assign cfg_write = cfg_valid & cfg_ready;

    // Clamp a written radix into 2..36.
    always_comb
    begin
        if (cfg_data[BASE_W-1:0] < BASE_MIN)
        begin
            base_wr = BASE_MIN;
        end
        else if (cfg_data[BASE_W-1:0] > BASE_MAX)
        begin
            base_wr = BASE_MAX;
        end
        else
        begin
            base_wr = cfg_data[BASE_W-1:0];
        end
    end

    // One restoring step: quotient bits shift in where dividend bits leave.
    assign trial = {rem_reg, dvd_reg[VALUE_W-1]};
    assign ge    = trial >= {1'b0, base_reg};

    always_comb
    begin
        base_next  = base_reg;
        limit_next = limit_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (busy_reg)
        begin
            dvd_next = {dvd_reg[VALUE_W-2:0], ge};
            rem_next = ge ? BASE_W'(trial - {1'b0, base_reg}) : trial[BASE_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BASE:
                begin
                    base_next = base_wr;
                    dvd_next  = limit_reg;
                end
                CFG_LIMIT:
                begin
                    limit_next = cfg_data;
                    dvd_next   = cfg_data;
                end
                default:
                begin
                    dvd_next = limit_reg;
                end
            endcase
            rem_next  = '0;
            cnt_next  = STEP_W'(DIV_STEPS - 1);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= BASE_RESET;
            limit_reg <= LIMIT_RESET;
            dvd_reg   <= QUOT_RESET;
            rem_reg   <= REM_RESET;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            base_reg  <= base_next;
            limit_reg <= limit_next;
            dvd_reg   <= dvd_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy             = busy_reg;
    assign limits.base      = base_reg;
    assign limits.quotient  = dvd_reg;
    assign limits.remainder = rem_reg;

    `RTTIP_ASSERT_NOW(a_div_exact, $fell(busy_reg),
        (dvd_reg * VALUE_W'(base_reg) + VALUE_W'(rem_reg)) == limit_reg)
    `RTTIP_ASSERT_NOW(a_rem_below_base, !busy_reg, rem_reg < base_reg)

endmodule

@@ rtl/rttip_accum.sv @@
// ----------------------------------------------------------------------------
// rttip_accum
// Multiply-add accumulator with cutoff check and the result register.
// ----------------------------------------------------------------------------
`include "radix_text_to_integer_parser_assert.svh"

module rttip_accum (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           word_valid,
    input  rttip_pkg::char_word_t          word,
    input  rttip_pkg::limit_set_t          limits,
    output logic                           advance,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rttip_pkg::VALUE_W-1:0]  parsed_value,
    output logic [rttip_pkg::STATUS_W-1:0] parse_status
);
    import rttip_pkg::*;

    logic [VALUE_W-1:0] acc_reg, acc_next, acc_upd, acc_mul;
    prog_t              prog_reg, prog_next, prog_upd;
    logic               bad_reg, bad_next, bad_upd;
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] value_reg, value_res;
    status_t            status_reg, status_res;
    logic               fire, emit;

    // A last word may only move on when the result register is free.
    assign fire = word_valid & ~(word.last & out_valid_reg & out_stall);
    assign emit = fire & word.last;
    assign advance = fire;

    assign acc_mul = acc_reg * VALUE_W'(limits.base);

    always_comb
    begin
        acc_upd  = acc_reg;
        prog_upd = prog_reg;
        bad_upd  = bad_reg;
        if (word.present && !bad_reg)
        begin
            if (word.digit >= limits.base)
            begin
                bad_upd = 1'b1;
            end
            else if (prog_reg == PROG_OVER || acc_reg > limits.quotient ||
                     (acc_reg == limits.quotient && word.digit > limits.remainder))
            begin
                prog_upd = PROG_OVER;
            end
            else
            begin
                acc_upd  = acc_mul + VALUE_W'(word.digit);
                prog_upd = PROG_DIGITS;
            end
        end
    end

    always_comb
    begin
        if (bad_upd)
        begin
            status_res = ST_INVALID;
            value_res  = '0;
        end
        else if (prog_upd != PROG_DIGITS)
        begin
            status_res = ST_OVERFLOW;
            value_res  = '0;
        end
        else
        begin
            status_res = ST_OK;
            value_res  = acc_upd;
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        prog_next = prog_reg;
        bad_next  = bad_reg;
        if (emit)
        begin
            acc_next  = '0;
            prog_next = PROG_NONE;
            bad_next  = 1'b0;
        end
        else if (fire)
        begin
            acc_next  = acc_upd;
            prog_next = prog_upd;
            bad_next  = bad_upd;
        end
    end

    assign out_valid_next = emit | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            prog_reg      <= PROG_NONE;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            prog_reg      <= prog_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            value_reg  <= value_res;
            status_reg <= status_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign parsed_value = value_reg;
    assign parse_status = status_reg;

    `RTTIP_ASSERT_NEXT(a_clear_after_last, emit,
        acc_reg == '0 && prog_reg == PROG_NONE && !bad_reg)
    `RTTIP_ASSERT_NOW(a_zero_unless_ok, out_valid_reg && status_reg != ST_OK,
        value_reg == '0)

endmodule

@@ rtl/radix_text_to_integer_parser.sv @@
// ----------------------------------------------------------------------------
// radix_text_to_integer_parser
// Parses a numeral one character per word in a base of 2..36 against a limit.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  -------   ---------------------   ----------------------------------------
//  in        in_valid / in_stall     character, char_present, last_char
//  out       out_valid / out_stall   parsed_value, parse_status
//  cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  One character word per cycle unless the bit-serial divider is busy or a
//  stalled result holds a last word; the accumulator loop is a single
//  multiply-add and compare per cycle and registers a result as it takes
//  its last word. cfg_ready and in_stall hold traffic off during limit / base.
//  Reset restores base 10 and an all-ones limit with its cutoff precomputed.
//  A stalled result blocks only a later last word; other words keep flowing.
// ----------------------------------------------------------------------------
module radix_text_to_integer_parser (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rttip_pkg::CHAR_W-1:0]      character,
    input  logic                              char_present,
    input  logic                              last_char,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rttip_pkg::VALUE_W-1:0]     parsed_value,
    output logic [rttip_pkg::STATUS_W-1:0]    parse_status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rttip_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rttip_pkg::VALUE_W-1:0]     cfg_data
);
    import rttip_pkg::*;

    // Held character word, decoded to a digit value (36 for a non-digit).
    char_word_t word;
    logic       word_valid;
    // Radix and cutoff split, stable whenever the divider is idle.
    limit_set_t limits;
    logic       div_busy;
    // Accumulator consumed the held word this cycle.
    logic       advance;

    rttip_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .character    (character),
        .char_present (char_present),
        .last_char    (last_char),
        .hold         (div_busy),
        .advance      (advance),
        .word_valid   (word_valid),
        .word         (word)
    );

    rttip_limit_div u_limit_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (div_busy),
        .limits    (limits)
    );

    // Hold the word back while the cutoff split is being recomputed.
    rttip_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (word_valid & ~div_busy),
        .word         (word),
        .limits       (limits),
        .advance      (advance),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .parsed_value (parsed_value),
        .parse_status (parse_status)
    );

endmodule

@@ tb/sv/radix_text_to_integer_parser_test.sv @@
// ============================================================================
// Radix text-to-integer parser testbench
// Feeds numerals one character word at a time under several radix and cutoff
// settings and checks each parsed value and status against a local model of
// the digit accumulator, its cutoff compare and its invalid/empty handling.
// ============================================================================
module radix_text_to_integer_parser_test;
    import rttip_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    // ASCII landmarks of the digit alphabet
    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] ASCII_DEL     = 8'h7F;

    // Non-digit bytes sitting right next to the digit and letter ranges
    localparam int NEAR_COUNT = 9;
    localparam logic [8*NEAR_COUNT-1:0] NEAR_DIGIT =
        {8'h00, 8'h20, 8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h7F};

    typedef struct {
        logic [VALUE_W-1:0] value;
        status_t            status;
    } parse_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [CHAR_W-1:0]      character;
    logic                   char_present;
    logic                   last_char;
    logic                   out_valid;
    logic                   out_stall;
    logic [VALUE_W-1:0]     parsed_value;
    logic [STATUS_W-1:0]    parse_status;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [VALUE_W-1:0]     cfg_data;

    // Local copy of the parser's configuration and numeral state
    logic [BASE_W-1:0]  radix;
    logic [VALUE_W-1:0] cutoff_limit;
    logic [VALUE_W-1:0] cutoff_quot;
    logic [BASE_W-1:0]  cutoff_rem;
    logic [VALUE_W-1:0] acc_value;
    prog_t              acc_progress;
    logic               acc_bad;

    parse_result_t expected_numerals[$];

    int  errors          = 0;
    int  words_sent      = 0;
    int  results_checked = 0;
    int  config_writes   = 0;
    int  cycle_count     = 0;
    int  receiver_hold   = 0;
    bit  steady_flow     = 1'b0;

    radix_text_to_integer_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .character    (character),
        .char_present (char_present),
        .last_char    (last_char),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .parsed_value (parsed_value),
        .parse_status (parse_status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d numerals still pending", $time,
                     expected_numerals.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Model: fold one accepted word into the numeral state and queue the
    // parse result when the word closes the numeral.
    // ------------------------------------------------------------------
    function automatic void accept_numeral_word(logic [CHAR_W-1:0] ch, logic present,
                                                logic last);
        logic [BASE_W-1:0] d;
        parse_result_t     r;
        // Skip absent characters; once a bad character is seen, stop looking
        if (present && !acc_bad)
        begin
            if (ch >= ASCII_ZERO && ch <= ASCII_NINE)
                d = BASE_W'(ch - ASCII_ZERO);
            else if (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z)
                d = BASE_W'(ch - ASCII_UPPER_A) + 6'd10;
            else if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z)
                d = BASE_W'(ch - ASCII_LOWER_A) + 6'd10;
            else
                d = DIGIT_NONE;
            if (d >= radix)
                acc_bad = 1'b1;
            // Compare against the cutoff before the multiply-add, so the
            // accumulator never wraps; digits after overflow are dropped.
            else if (acc_progress == PROG_OVER || acc_value > cutoff_quot ||
                     (acc_value == cutoff_quot && d > cutoff_rem))
                acc_progress = PROG_OVER;
            else
            begin
                acc_value    = acc_value * 64'(radix) + 64'(d);
                acc_progress = PROG_DIGITS;
            end
        end
        if (last)
        begin
            r.value = '0;
            if (acc_bad)
                r.status = ST_INVALID;
            else if (acc_progress != PROG_DIGITS)
                r.status = ST_OVERFLOW;   // overflow, or no digits at all
            else
            begin
                r.status = ST_OK;
                r.value  = acc_value;
            end
            expected_numerals.push_back(r);
            acc_value    = '0;
            acc_progress = PROG_NONE;
            acc_bad      = 1'b0;
        end
    endfunction

    // Model: register write, with radix clamping and cutoff split
    function automatic void apply_register(logic [CFG_INDEX_W-1:0] idx,
                                           logic [VALUE_W-1:0] data);
        logic [BASE_W-1:0] b;
        if (idx == CFG_BASE)
        begin
            b = data[BASE_W-1:0];
            if (b < BASE_MIN)
                b = BASE_MIN;
            else if (b > BASE_MAX)
                b = BASE_MAX;
            radix = b;
        end
        else
            cutoff_limit = data;
        cutoff_quot = cutoff_limit / 64'(radix);
        cutoff_rem  = BASE_W'(cutoff_limit % 64'(radix));
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(logic [BASE_W-1:0] d, bit upper);
        if (d < 6'd10)
            return ASCII_ZERO + CHAR_W'(d);
        return (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + CHAR_W'(d) - 8'd10;
    endfunction

    // Random upper bits around a chosen radix field, to show they are ignored
    function automatic logic [VALUE_W-1:0] with_noise(logic [BASE_W-1:0] low);
        logic [VALUE_W-1:0] w;
        w = {$urandom, $urandom};
        w[BASE_W-1:0] = low;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls, or a counted hold-off when requested
    // ------------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (receiver_hold > 0)
            begin
                out_stall <= 1'b1;
                receiver_hold--;
            end
            else
                out_stall <= !steady_flow && ($urandom_range(99) < 21);
        end
    end

    // Compare each taken result with the oldest pending numeral
    always @(posedge clk)
    begin : check_result
        parse_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_numerals.size() == 0)
            begin
                $display("%0t: unexpected result, value %h status %0d", $time,
                         parsed_value, parse_status);
                errors++;
            end
            else
            begin
                want = expected_numerals.pop_front();
                results_checked++;
                if (parsed_value !== want.value)
                begin
                    $display("%0t: parsed_value expected %h got %h", $time,
                             want.value, parsed_value);
                    errors++;
                end
                if (parse_status !== want.status)
                begin
                    $display("%0t: parse_status expected %0d got %0d", $time,
                             want.status, parse_status);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------

    // Offer one word; idle a random gap first, hold it until taken
    task automatic send_word(logic [CHAR_W-1:0] ch, logic present, logic last);
        int gap;
        gap = 0;
        if (!steady_flow)
            while (gap < 12 && $urandom_range(99) < 21)
                gap++;
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        character    <= ch;
        char_present <= present;
        last_char    <= last;
        do
            @(posedge clk);
        while (in_stall);
        accept_numeral_word(ch, present, last);
        if (present || last)
            words_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b1, i == s.len() - 1);
    endtask

    // Drop valid, wait out every pending result plus the pipeline tail
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_numerals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Registers change only with the parser idle; the divider pass that
    // follows is covered by cfg_ready and in_stall.
    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [VALUE_W-1:0] data);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(idx, data);
        config_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One numeral: mostly well formed, some right at the cutoff, some with a
    // bad character planted, some empty; absent words sprinkled in between.
    task automatic send_random_numeral();
        logic [CHAR_W-1:0]  text[$];
        logic [BASE_W-1:0]  digs[$];
        logic [VALUE_W-1:0] rest;
        logic [CHAR_W-1:0]  bad;
        int                 kind;
        int                 n;
        int                 pos;
        int                 tail;
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            send_word(CHAR_W'($urandom), 1'b0, 1'b1);
            return;
        end
        if (kind < 30)
        begin
            // Spell the limit itself, then nudge it across or below the cutoff
            rest = cutoff_limit;
            do
            begin
                digs.push_front(BASE_W'(rest % 64'(radix)));
                rest = rest / 64'(radix);
            end
            while (rest != 0);
            tail = digs.size() - 1;
            case ($urandom_range(3))
                1: if (digs[tail] < radix - 6'd1) digs[tail] = digs[tail] + 6'd1;
                2: digs.push_back(BASE_W'($urandom_range(radix - 1)));
                3: if (digs[tail] > 6'd0) digs[tail] = digs[tail] - 6'd1;
                default: ;
            endcase
            repeat ($urandom_range(2))
                digs.push_front(6'd0);
        end
        else
        begin
            n = ($urandom_range(3) == 0) ? $urandom_range(24, 1) : $urandom_range(4, 1);
            repeat (n)
                digs.push_back(BASE_W'($urandom_range(radix - 1)));
        end
        foreach (digs[i])
            text.push_back(digit_char(digs[i], 1'($urandom_range(1))));
        if (kind >= 30 && kind < 44)
        begin
            case ($urandom_range(2))
                0: bad = CHAR_W'($urandom_range(255, 128));
                1: bad = NEAR_DIGIT[8*$urandom_range(NEAR_COUNT - 1) +: 8];
                default:
                    bad = (radix < BASE_MAX) ?
                          digit_char(BASE_W'($urandom_range(35, radix)), 1'($urandom_range(1))) :
                          ASCII_DEL;
            endcase
            pos = $urandom_range(text.size() - 1);
            text[pos] = bad;
        end
        foreach (text[i])
        begin
            if ($urandom_range(99) < 5)
                send_word(CHAR_W'($urandom), 1'b0, 1'b0);
            send_word(text[i], 1'b1, i == text.size() - 1);
        end
    endtask

    task automatic run_phase(logic [VALUE_W-1:0] base_word, logic [VALUE_W-1:0] limit,
                             int count);
        int target;
        write_register(CFG_BASE, base_word);
        write_register(CFG_LIMIT, limit);
        target = words_sent + count;
        while (words_sent < target)
            send_random_numeral();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: base 10 and an all-ones limit
    task automatic test_reset_defaults();
        send_word(8'hA5, 1'b0, 1'b1);     // empty numeral
        send_text("a");                   // letter not below base ten
        send_word("9", 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);     // absent word mid-numeral
        send_word(8'hFF, 1'b1, 1'b1);     // non-ASCII byte
        send_text("42");
    endtask

    // Exact cutoff hits, overflow, and invalid after overflow
    task automatic test_cutoff_edges();
        write_register(CFG_BASE, with_noise(6'd37));   // clamps to 36
        send_text("3W5e11264SGSf");                    // all ones in base 36
        write_register(CFG_LIMIT, 64'd100);
        write_register(CFG_BASE, with_noise(6'd10));
        send_text("101");
        send_text("1015/");
    endtask

    task automatic test_random_sweep();
        run_phase(with_noise(6'd0), {$urandom, $urandom}, 60);
        run_phase(with_noise(6'd1), LIMIT_RESET, 60);
        run_phase(with_noise(6'd8), 64'($urandom), 60);
        run_phase(with_noise(6'd10), 64'd0, 60);
        run_phase(with_noise(6'd63), {$urandom, $urandom}, 60);
        run_phase(with_noise(6'd36), 64'($urandom_range(5000)), 60);
        run_phase(with_noise(6'd2), 64'd1, 40);
        run_phase(with_noise(BASE_W'($urandom_range(35, 3))),
                  {$urandom, $urandom} >> $urandom_range(63), 60);
    endtask

    // Back-to-back words with no idling on either side
    task automatic test_steady_flow();
        steady_flow = 1'b1;
        run_phase(with_noise(6'd16), LIMIT_RESET, 60);
        steady_flow = 1'b0;
    endtask

    // Freeze the result side long enough to back the parser up, then let the
    // sender pause until everything has drained before resuming.
    task automatic test_backpressure();
        int target;
        write_register(CFG_BASE, with_noise(6'd10));
        write_register(CFG_LIMIT, LIMIT_RESET);
        receiver_hold = 300;
        repeat (40)
            send_word(digit_char(BASE_W'($urandom_range(9)), 1'b0), 1'b1, 1'b1);
        drain_results();
        target = words_sent + 30;
        while (words_sent < target)
            send_random_numeral();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        character    = '0;
        char_present = 1'b0;
        last_char    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_BASE;
        cfg_data     = '0;
        acc_value    = '0;
        acc_progress = PROG_NONE;
        acc_bad      = 1'b0;
        radix        = BASE_RESET;
        cutoff_limit = LIMIT_RESET;
        cutoff_quot  = LIMIT_RESET / 64'(BASE_RESET);
        cutoff_rem   = BASE_W'(LIMIT_RESET % 64'(BASE_RESET));

        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_cutoff_edges();
        test_random_sweep();
        test_steady_flow();
        test_backpressure();

        drain_results();
        $display("Sent %0d character words over %0d register writes; checked %0d results.",
                 words_sent, config_writes, results_checked);
        $display("Covered radix 2..36 with clamping, zero to all-ones limits, and %0d errors.",
                 errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
